// File: rtl/tarrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tarrp_pkg: shared types and codes of the trigger slot controller
// Opcode and status codes, field widths and the request/response structs
// that pass between the top level and the slot store.
// ----------------------------------------------------------------------------
package tarrp_pkg;

    localparam int OPCODE_W  = 2;
    localparam int SRC_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int SLOT_ID_W = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_EVENT = 2'd1,
        OP_TAKE  = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_SLOT      = 2'd1,
        ST_NONE_PENDING = 2'd2,
        ST_UNBOUND      = 2'd3
    } t_status;

    typedef struct packed {
        logic             vld;
        t_opcode          op;
        logic [SRC_W-1:0] src;
    } t_req;

    typedef struct packed {
        logic                 vld;
        t_status              status;
        logic [SLOT_ID_W-1:0] slot_id;
    } t_rsp;

endpackage
`default_nettype wire

// File: rtl/tarrp_first_set.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tarrp_first_set: lowest set bit finder
// Reports whether any bit of the vector is set and the index of the lowest.
// ----------------------------------------------------------------------------
module tarrp_first_set #(
    parameter int W     = 15,
    parameter int IDX_W = 4
) (
    input  wire logic [W-1:0]     i_vec,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_idx
);

    always_comb begin
        o_idx = '0;
        // walk down so the lowest set bit wins
        for (int i = W - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_idx = IDX_W'(i);
            end
        end
    end

    assign o_found = |i_vec;

endmodule
`default_nettype wire

// File: rtl/tarrp_slots.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tarrp_slots: trigger slot store and per-item update
// Holds in-use and pending bits, the bound source of each slot and the
// round-robin scan position; decides one request beat and updates state.
// ----------------------------------------------------------------------------
module tarrp_slots
    import tarrp_pkg::*;
#(
    parameter int NUM_SLOTS = 15
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    output t_rsp      o_rsp
);

    localparam int IDX_W = $clog2(NUM_SLOTS);

    logic [NUM_SLOTS-1:0] r_in_use, n_in_use;
    logic [NUM_SLOTS-1:0] r_pending, n_pending;
    logic [IDX_W-1:0]     r_scan, n_scan;
    logic [SRC_W-1:0]     r_source [NUM_SLOTS];

    logic                 src_we;
    logic [NUM_SLOTS-1:0] match_vec;
    logic [NUM_SLOTS-1:0] upper_pend;

    logic                 free_found, match_found, hi_found, any_found;
    logic [IDX_W-1:0]     free_idx, match_idx, hi_idx, any_idx, take_idx;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            match_vec[i]  = r_in_use[i] && (r_source[i] == i_req.src);
            // pending slots at or after the scan position
            upper_pend[i] = r_pending[i] && (i >= int'(r_scan));
        end
    end

    tarrp_first_set #(.W(NUM_SLOTS), .IDX_W(IDX_W)) u_free (
        .i_vec   (~r_in_use),
        .o_found (free_found),
        .o_idx   (free_idx)
    );

    tarrp_first_set #(.W(NUM_SLOTS), .IDX_W(IDX_W)) u_match (
        .i_vec   (match_vec),
        .o_found (match_found),
        .o_idx   (match_idx)
    );

    tarrp_first_set #(.W(NUM_SLOTS), .IDX_W(IDX_W)) u_hi (
        .i_vec   (upper_pend),
        .o_found (hi_found),
        .o_idx   (hi_idx)
    );

    tarrp_first_set #(.W(NUM_SLOTS), .IDX_W(IDX_W)) u_any (
        .i_vec   (r_pending),
        .o_found (any_found),
        .o_idx   (any_idx)
    );

    // wrap to the lowest pending slot when nothing lies above the scan point
    assign take_idx = hi_found ? hi_idx : any_idx;

    always_comb begin
        n_in_use       = r_in_use;
        n_pending      = r_pending;
        n_scan         = r_scan;
        src_we         = 1'b0;
        o_rsp.vld      = i_req.vld;
        o_rsp.status   = ST_OK;
        o_rsp.slot_id  = '0;
        if (i_req.vld) begin
            case (i_req.op)
                OP_ALLOC: begin
                    if (free_found) begin
                        n_in_use[free_idx] = 1'b1;
                        src_we             = 1'b1;
                        o_rsp.slot_id      = SLOT_ID_W'(free_idx);
                    end else begin
                        o_rsp.status = ST_NO_SLOT;
                    end
                end
                OP_EVENT: begin
                    if (match_found) begin
                        n_pending[match_idx] = 1'b1;
                        o_rsp.slot_id        = SLOT_ID_W'(match_idx);
                    end else begin
                        o_rsp.status = ST_UNBOUND;
                    end
                end
                OP_TAKE: begin
                    if (any_found) begin
                        n_pending[take_idx] = 1'b0;
                        n_scan              = take_idx;
                        o_rsp.slot_id       = SLOT_ID_W'(take_idx);
                    end else begin
                        o_rsp.status = ST_NONE_PENDING;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use  <= '0;
            r_pending <= '0;
            r_scan    <= '0;
        end else begin
            r_in_use  <= n_in_use;
            r_pending <= n_pending;
            r_scan    <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (src_we) begin
            r_source[free_idx] <= i_req.src;
        end
    end

endmodule
`default_nettype wire

// File: rtl/trigger_alloc_round_robin_pending.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trigger_alloc_round_robin_pending: trigger slot controller
// Allocates trigger slots to pin sources, marks them pending on pin events
// and serves pending slots in round-robin order.
// ----------------------------------------------------------------------------
// A command beat is taken whenever start is high; busy stays low, so one
// command enters every cycle. Each command gives exactly one result beat on
// o_valid: the input register feeds the slot update, which is combinational,
// and the result register captures its outcome, so the beat passes the input
// register and then the result register. The updated slot state already
// feeds the next command. The receiver cannot stall, so results must be
// captured when o_valid is high.
// ----------------------------------------------------------------------------
module trigger_alloc_round_robin_pending
    import tarrp_pkg::*;
#(
    parameter int NUM_SLOTS = 15
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire logic [OPCODE_W-1:0]  i_opcode,
    input  wire logic [SRC_W-1:0]     i_pin_source,
    output logic                      busy,
    output logic                      o_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic [SLOT_ID_W-1:0]      o_slot_id
);

    t_req r_req;
    t_rsp rsp;

    logic                 r_valid;
    t_status              r_status;
    logic [SLOT_ID_W-1:0] r_slot_id;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.vld <= 1'b0;
        end else begin
            r_req.vld <= start && !busy;
        end
        r_req.op  <= t_opcode'(i_opcode);
        r_req.src <= i_pin_source;
    end

    tarrp_slots #(.NUM_SLOTS(NUM_SLOTS)) u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= rsp.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= rsp.status;
        r_slot_id <= rsp.slot_id;
    end

    assign o_valid   = r_valid;
    assign o_status  = STATUS_W'(r_status);
    assign o_slot_id = r_slot_id;

endmodule
`default_nettype wire
